>>> hw/rtl/assert_macros.svh
// Assertion helpers for the picker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/wrbp_pkg.sv
`timescale 1ns / 1ps
package wrbp_pkg;

	localparam int MAX_BACKENDS_DEF = 16;
	localparam int RATE_BITS_DEF    = 16;

	localparam int OPCODE_W     = 2;
	localparam int NODE_ID_W    = 32;
	localparam int ENTRY_RATE_W = 16;
	localparam int FRAC_W       = 16;
	localparam int MASK_W       = 16;
	localparam int SLOT_W       = 4;
	localparam int TOTAL_W      = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SELECT = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [NODE_ID_W-1:0]    entry_node_id;
		logic [ENTRY_RATE_W-1:0] entry_rate;
		logic [FRAC_W-1:0]       rand_fraction;
		logic [MASK_W-1:0]       available_mask;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_W-1:0]    picked_slot;
		logic [NODE_ID_W-1:0] picked_node_id;
		logic                 overflow;
	} rsp_t;

	// table commands from the sequencer
	typedef struct packed {
		logic clr;
		logic app;
	} tbl_cmd_t;

endpackage

>>> hw/rtl/weighted_random_backend_picker.sv
`timescale 1ns / 1ps
// Weighted random backend picker. Holds a route table of up to MAX_BACKENDS backends
// (node id and rate) with a saturating 20-bit rate total. Each request carries an opcode:
// clear empties the table, append adds one entry (overflow set when full), select does a
// roulette-wheel pick: target = (rand_fraction * total) >> 16, candidate is the first slot
// whose cumulative rate exceeds it; if that slot is not in available_mask a circular scan
// from the slot after it returns the first available one, else found is 0. Exactly one
// response per request. One request is in flight at a time: req_stall is high from
// acceptance until the response is loaded into the output register, which may still be
// waiting on rsp_stall while the next request is taken. Clear, append and no-op pass
// through EXEC to EMIT, where the response is loaded once the output register is free;
// select walks the single-read rate table one slot a cycle for the cumulative sum, then
// one slot a cycle for the fallback scan. The next request can be taken the cycle after
// the response is loaded.
`include "assert_macros.svh"
module weighted_random_backend_picker
	import wrbp_pkg::*;
#(
	parameter int MAX_BACKENDS = MAX_BACKENDS_DEF,
	parameter int RATE_BITS    = RATE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IDX_W = $clog2(MAX_BACKENDS);
	localparam int CNT_W = $clog2(MAX_BACKENDS + 1);
	// stored rate width: rate is masked to RATE_BITS, port carries 16 bits
	localparam int RW    = (RATE_BITS < ENTRY_RATE_W) ? RATE_BITS : ENTRY_RATE_W;
	localparam int CUM_W = RW + CNT_W;
	localparam int CMP_W = (CUM_W > TOTAL_W) ? CUM_W : TOTAL_W;
	localparam int PROD_W = FRAC_W + TOTAL_W;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BACKENDS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_CHECK,
		ST_FALL,
		ST_PICK,
		ST_EMIT
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [IDX_W-1:0]     idx_q;     // slot whose rate sits in the read register
	logic [CUM_W-1:0]     cum_q;
	logic [TOTAL_W-1:0]   sel_q;
	logic [CNT_W-1:0]     cand_q;    // == count when no slot qualified
	logic [CNT_W-1:0]     pos_q;     // fallback position
	logic [CNT_W-1:0]     left_q;    // fallback slots still to visit
	logic [IDX_W-1:0]     pick_q;
	logic                 found_q;
	logic                 ovf_q;

	tbl_cmd_t             tbl_cmd;
	logic [IDX_W-1:0]     rate_addr;
	logic [RW-1:0]        rate_rd;
	logic [NODE_ID_W-1:0] node_rd;
	logic [CNT_W-1:0]     tbl_cnt;
	logic [TOTAL_W-1:0]   tbl_total;
	logic                 tbl_full;

	logic [PROD_W-1:0]    prod;
	logic [CUM_W-1:0]     cum_sum;
	logic                 hit;
	logic                 last_slot;
	logic                 cand_avail;
	logic                 pos_avail;
	logic                 pick_avail;
	logic [CNT_W:0]       start_a;
	logic [CNT_W:0]       start_b;
	logic [CNT_W-1:0]     start_pos;
	logic                 out_free;

	function automatic logic slot_avail(input logic [CNT_W-1:0] s,
	                                    input logic [MASK_W-1:0] m);
		logic [31:0] sw;
		sw = 32'(s);
		// slots beyond the mask width are never available
		return (sw < 32'(MASK_W)) && m[sw[SLOT_W-1:0]];
	endfunction

	wrbp_route_table #(
		.MAX_BACKENDS (MAX_BACKENDS),
		.RATE_W       (RW)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tbl_cmd),
		.app_node  (req_q.entry_node_id),
		.app_rate  (req_q.entry_rate[RW-1:0]),
		.rate_addr (rate_addr),
		.rate_rd   (rate_rd),
		.node_addr (pick_q),
		.node_rd   (node_rd),
		.cnt       (tbl_cnt),
		.total     (tbl_total),
		.full      (tbl_full)
	);

	always_comb begin
		tbl_cmd.clr = (state_q == ST_EXEC) && (req_q.opcode == OP_CLEAR);
		tbl_cmd.app = (state_q == ST_EXEC) && (req_q.opcode == OP_APPEND);
	end

	// prefetch: next slot while scanning, slot zero before
	assign rate_addr = (state_q == ST_SCAN) ? idx_q + IDX_W'(1) : idx_q;

	assign prod      = PROD_W'(req_q.rand_fraction) * PROD_W'(tbl_total);
	assign cum_sum   = cum_q + CUM_W'(rate_rd);
	assign hit       = CMP_W'(cum_sum) > CMP_W'(sel_q);
	assign last_slot = (CNT_W'(idx_q) == tbl_cnt - CNT_W'(1));

	assign cand_avail = (cand_q < tbl_cnt) && slot_avail(cand_q, req_q.available_mask);
	assign pos_avail  = slot_avail(pos_q, req_q.available_mask);
	assign pick_avail = slot_avail(CNT_W'(pick_q), req_q.available_mask);

	// fallback start = (cand + 1) mod count, cand <= count
	always_comb begin
		start_a = (CNT_W + 1)'(cand_q) + (CNT_W + 1)'(1);
		start_b = (start_a >= (CNT_W + 1)'(tbl_cnt)) ? start_a - (CNT_W + 1)'(tbl_cnt)
		                                              : start_a;
		// single-entry table wraps to slot zero
		start_pos = (start_b >= (CNT_W + 1)'(tbl_cnt)) ? '0 : start_b[CNT_W-1:0];
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			cum_q       <= '0;
			sel_q       <= '0;
			cand_q      <= '0;
			pos_q       <= '0;
			left_q      <= '0;
			pick_q      <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
		end else begin
			// response taken; in EMIT the load below decides the flag
			if (rsp_valid_q && !rsp_stall && state_q != ST_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						idx_q   <= '0;
						cum_q   <= '0;
						found_q <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (req_q.opcode) inside
						OP_APPEND: begin
							ovf_q   <= tbl_full;
							state_q <= ST_EMIT;
						end
						OP_SELECT: begin
							sel_q   <= prod[FRAC_W +: TOTAL_W];
							state_q <= (tbl_cnt == '0) ? ST_EMIT : ST_SCAN;
						end
						OP_CLEAR, OP_NOP: begin
							state_q <= ST_EMIT;
						end
						default: begin
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_SCAN: begin
					if (hit) begin
						cand_q  <= CNT_W'(idx_q);
						state_q <= ST_CHECK;
					end else if (last_slot) begin
						cand_q  <= tbl_cnt;
						state_q <= ST_CHECK;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						cum_q <= cum_sum;
					end
				end
				ST_CHECK: begin
					if (cand_avail) begin
						pick_q  <= cand_q[IDX_W-1:0];
						found_q <= 1'b1;
						state_q <= ST_PICK;
					end else begin
						pos_q   <= start_pos;
						left_q  <= tbl_cnt;
						state_q <= ST_FALL;
					end
				end
				ST_FALL: begin
					if (pos_avail) begin
						pick_q  <= pos_q[IDX_W-1:0];
						found_q <= 1'b1;
						state_q <= ST_PICK;
					end else if (left_q == CNT_W'(1)) begin
						state_q <= ST_EMIT;
					end else begin
						left_q <= left_q - CNT_W'(1);
						pos_q  <= (pos_q == tbl_cnt - CNT_W'(1)) ? '0 : pos_q + CNT_W'(1);
					end
				end
				ST_PICK: begin
					// node table read lands this edge
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						rsp_q.found          <= found_q;
						rsp_q.picked_slot    <= found_q ? SLOT_W'(pick_q) : '0;
						rsp_q.picked_node_id <= found_q ? node_rd : '0;
						rsp_q.overflow       <= ovf_q;
						rsp_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, tbl_cnt <= MAX_CNT)
	`ASSERT_IMP(a_scan_in_table, clk, arst_n, state_q == ST_SCAN, CNT_W'(idx_q) < tbl_cnt)
	`ASSERT_IMP(a_fall_in_table, clk, arst_n, state_q == ST_FALL, pos_q < tbl_cnt)
	`ASSERT_IMP(a_pick_avail, clk, arst_n, state_q == ST_PICK, found_q && pick_avail)
	`ASSERT_IMP(a_rsp_excl, clk, arst_n, rsp_valid_q, !(rsp_q.found && rsp_q.overflow))

endmodule

>>> hw/rtl/wrbp_route_table.sv
`timescale 1ns / 1ps
module wrbp_route_table
	import wrbp_pkg::*;
#(
	parameter int MAX_BACKENDS = MAX_BACKENDS_DEF,
	parameter int RATE_W       = ENTRY_RATE_W,
	localparam int IDX_W       = $clog2(MAX_BACKENDS),
	localparam int CNT_W       = $clog2(MAX_BACKENDS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_cmd_t             cmd,
	input  logic [NODE_ID_W-1:0] app_node,
	input  logic [RATE_W-1:0]    app_rate,
	input  logic [IDX_W-1:0]     rate_addr,
	output logic [RATE_W-1:0]    rate_rd,
	input  logic [IDX_W-1:0]     node_addr,
	output logic [NODE_ID_W-1:0] node_rd,
	output logic [CNT_W-1:0]     cnt,
	output logic [TOTAL_W-1:0]   total,
	output logic                 full
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BACKENDS);

	logic [NODE_ID_W-1:0] node_mem [MAX_BACKENDS];
	logic [RATE_W-1:0]    rate_mem [MAX_BACKENDS];
	logic [NODE_ID_W-1:0] node_rd_q;
	logic [RATE_W-1:0]    rate_rd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [TOTAL_W:0]     total_sum;

	assign full      = (cnt_q == MAX_CNT);
	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(app_rate);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
		end else if (cmd.clr) begin
			cnt_q   <= '0;
			total_q <= '0;
		end else if (cmd.app && !full) begin
			cnt_q   <= cnt_q + CNT_W'(1);
			// saturating running total
			total_q <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.app && !full) begin
			node_mem[cnt_q[IDX_W-1:0]] <= app_node;
			rate_mem[cnt_q[IDX_W-1:0]] <= app_rate;
		end
		rate_rd_q <= rate_mem[rate_addr];
		node_rd_q <= node_mem[node_addr];
	end

	assign rate_rd = rate_rd_q;
	assign node_rd = node_rd_q;
	assign cnt     = cnt_q;
	assign total   = total_q;

endmodule

>>> verif/weighted_random_backend_picker_tb.sv
`timescale 1ns / 1ps
module weighted_random_backend_picker_tb;
	import wrbp_pkg::*;

	// Roughly 1850 random requests plus idling; the limit covers that several times over.
	localparam int CYCLE_LIMIT  = 800000;
	localparam int RANDOM_ITEMS = 1850;
	// Idle tail after the last expected response, so any straggler at the end is caught.
	localparam int TAIL_CYCLES  = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Route table as the testbench believes it to be.
	logic [NODE_ID_W-1:0]    node_ids [MAX_BACKENDS_DEF];
	logic [ENTRY_RATE_W-1:0] rates    [MAX_BACKENDS_DEF];
	int unsigned             n_entries = 0;
	int unsigned             rate_sum  = 0;

	rsp_t expected_routes [$];
	int   mismatches = 0;
	int   sent = 0;
	int   cycles = 0;
	bit   no_idle = 1'b0;

	// Directed rows: the expected response is typed in only where it is obvious.
	typedef struct packed {
		req_t stim;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	weighted_random_backend_picker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// Global watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Works out the response to one request and updates the table copy.
	// Roulette wheel: target = (fraction * total) >> 16, candidate is the first slot
	// whose running sum of rates exceeds it; failing that (or if the candidate is not
	// connected) a circular scan from the slot after it, wrapping modulo the count.
	// With no candidate at all the scan starts after slot n_entries, i.e. (n+1) mod n.
	function automatic rsp_t route_outcome(req_t r);
		rsp_t        o;
		logic [35:0] target;
		int unsigned cum, cand, start, s, pick, i, total;
		bit          hit;
		o = '0;
		hit = 1'b0;
		pick = 0;
		case (r.opcode)
			OP_CLEAR: begin
				n_entries = 0;
				rate_sum  = 0;
			end
			OP_APPEND: begin
				if (n_entries < MAX_BACKENDS_DEF) begin
					node_ids[n_entries] = r.entry_node_id;
					rates[n_entries]    = r.entry_rate;
					n_entries++;
					// total is 20 bits and saturates
					total = rate_sum + r.entry_rate;
					rate_sum = (total > TOTAL_MAX) ? int'(TOTAL_MAX) : total;
				end else begin
					o.overflow = 1'b1;
				end
			end
			OP_SELECT: begin
				if (n_entries != 0) begin
					target = (36'(r.rand_fraction) * 36'(rate_sum)) >> 16;
					cum  = 0;
					cand = n_entries;
					for (i = 0; i < n_entries; i++) begin
						cum += rates[i];
						if (cand == n_entries && 36'(cum) > target)
							cand = i;
					end
					if (cand < n_entries && r.available_mask[cand]) begin
						hit  = 1'b1;
						pick = cand;
					end else begin
						start = (cand + 1) % n_entries;
						for (i = 0; i < n_entries; i++) begin
							s = (start + i) % n_entries;
							if (!hit && r.available_mask[s]) begin
								hit  = 1'b1;
								pick = s;
							end
						end
					end
					if (hit) begin
						o.found          = 1'b1;
						o.picked_slot    = pick[SLOT_W-1:0];
						o.picked_node_id = node_ids[pick];
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic req_t mk_req(opcode_t op, logic [NODE_ID_W-1:0] id,
			logic [ENTRY_RATE_W-1:0] rate, logic [FRAC_W-1:0] frac,
			logic [MASK_W-1:0] mask);
		req_t r;
		r.opcode         = op;
		r.entry_node_id  = id;
		r.entry_rate     = rate;
		r.rand_fraction  = frac;
		r.available_mask = mask;
		return r;
	endfunction

	function automatic req_t random_req();
		return mk_req(opcode_t'(OPCODE_W'($urandom_range(3))), NODE_ID_W'($urandom()),
			ENTRY_RATE_W'($urandom()), FRAC_W'($urandom()), MASK_W'($urandom()));
	endfunction

	function automatic void add_row(req_t s, bit typed, rsp_t want);
		dir_row_t row;
		row.stim  = s;
		row.typed = typed;
		row.want  = want;
		dir_rows = {dir_rows, row};
	endfunction

	// Offers one request, optionally after a few idle cycles, and waits for the handshake.
	// Called only right after a rising edge; each step sees a single NBA on req_valid.
	task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t predicted;
		while (!no_idle && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// accepted at this edge
		predicted = route_outcome(r);
		expected_routes = {expected_routes, (typed ? typed_rsp : predicted)};
		if (r.opcode != OP_NOP)
			sent++;
	endtask

	// Holds the request side off until every outstanding response is back.
	task automatic drain_pipeline();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_routes.size() != 0);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			mismatches++;
		end
	endfunction

	// Response side: check against the oldest expectation, then decide next cycle's stall.
	always @(posedge clk) begin : rsp_side
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_routes.size() == 0) begin
				$display("%0t ns: unexpected response, expected none, actual 0x%0h",
					$time, rsp);
				mismatches++;
			end else begin
				want = expected_routes.pop_front();
				check_field("found", 32'(want.found), 32'(rsp.found));
				check_field("picked_slot", 32'(want.picked_slot), 32'(rsp.picked_slot));
				check_field("picked_node_id", want.picked_node_id, rsp.picked_node_id);
				check_field("overflow", 32'(want.overflow), 32'(rsp.overflow));
			end
		end
		rsp_stall <= !no_idle && ($urandom_range(99) < 19);
	end

	initial begin : stimulus
		rsp_t    none;
		rsp_t    full;
		req_t    r;
		int      i, k, m, burst;
		int      roll;

		none = '0;
		full = '0;
		full.overflow = 1'b1;

		// Empty table: select finds nothing.
		add_row(mk_req(OP_SELECT, '1, '1, '1, '1), 1'b1, none);
		// No-op with every payload bit set.
		add_row(mk_req(OP_NOP, '1, '1, '1, '1), 1'b1, none);
		// Two zero-rate entries: total stays zero.
		add_row(mk_req(OP_APPEND, '1, '0, '0, '0), 1'b1, none);
		add_row(mk_req(OP_APPEND, '0, '0, '1, '1), 1'b1, none);
		// Zero total: no candidate, scan starts at (n+1) mod n.
		add_row(mk_req(OP_SELECT, '0, '0, '1, '1), 1'b0, none);
		// Nothing connected.
		add_row(mk_req(OP_SELECT, '1, '1, '1, '0), 1'b1, none);
		// Clear carrying an all-ones payload.
		add_row(mk_req(OP_CLEAR, '1, '1, '1, '1), 1'b1, none);
		// Fill the table: rate 1 in slot 0, full-scale rate in slot 15.
		for (i = 0; i < MAX_BACKENDS_DEF; i++)
			add_row(mk_req(OP_APPEND, i * 32'h1111_1111,
				(i == 0) ? 16'h0001 : (i == 15) ? 16'hFFFF : 16'(i * 16'h0111),
				'0, '0), 1'b1, none);
		// Full table: append dropped.
		add_row(mk_req(OP_APPEND, '1, '1, '0, '0), 1'b1, full);
		// Top of the wheel lands on slot 15, not connected: wraps round to slot 0.
		add_row(mk_req(OP_SELECT, '0, '0, '1, 16'h0001), 1'b0, none);
		// Bottom of the wheel lands on slot 0, not connected: falls to slot 1.
		add_row(mk_req(OP_SELECT, '0, '0, '0, 16'hFFFE), 1'b0, none);
		add_row(mk_req(OP_SELECT, '0, '0, 16'h8000, '0), 1'b1, none);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[j])
			send_request(dir_rows[j].stim, dir_rows[j].typed, dir_rows[j].want);

		// Let everything settle once before the random part.
		drain_pipeline();

		sent  = 0;
		burst = 0;
		while (sent < RANDOM_ITEMS) begin
			burst++;
			// long quiet stretch with no idling on either side
			no_idle = (sent >= 700 && sent < 1000);
			if (burst % 12 == 0)
				drain_pipeline();
			roll = $urandom_range(99);
			if (roll < 8) begin
				// noise: anything at all
				k = $urandom_range(1, 4);
				repeat (k) send_request(random_req(), 1'b0, none);
			end else begin
				// usually a fresh table; otherwise entries pile up towards overflow
				if ($urandom_range(99) >= 15) begin
					r = random_req();
					r.opcode = OP_CLEAR;
					send_request(r, 1'b0, none);
				end
				k = ($urandom_range(9) == 0) ? $urandom_range(16, 19) : $urandom_range(0, 16);
				repeat (k) begin
					r = random_req();
					r.opcode = OP_APPEND;
					case ($urandom_range(7))
						0: r.entry_rate = '0;
						1: r.entry_rate = '1;
						2: r.entry_rate = 16'($urandom_range(1, 16));
						default: ;
					endcase
					send_request(r, 1'b0, none);
				end
				m = $urandom_range(1, 8);
				repeat (m) begin
					r = random_req();
					r.opcode = ($urandom_range(19) == 0) ? OP_NOP : OP_SELECT;
					case ($urandom_range(5))
						0: r.rand_fraction = '0;
						1: r.rand_fraction = '1;
						default: ;
					endcase
					case ($urandom_range(7))
						0: r.available_mask = '1;
						1: r.available_mask = '0;
						2: r.available_mask = 16'(1) << $urandom_range(15);
						3: r.available_mask = ~(16'(1) << $urandom_range(15));
						default: ;
					endcase
					send_request(r, 1'b0, none);
				end
			end
		end
		no_idle = 1'b0;

		req_valid <= 1'b0;
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_routes.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> weighted_random_backend_picker.f
+incdir+hw/rtl
hw/rtl/wrbp_pkg.sv
hw/rtl/wrbp_route_table.sv
hw/rtl/weighted_random_backend_picker.sv
verif/weighted_random_backend_picker_tb.sv
